### hw/rtl/char_lcd_i2c_expander_sequencer_macros.svh
// Assertion helpers for the character LCD expander sequencer.
// Each macro names the assertion, the clock, the active-low reset,
// the triggering condition and the expected consequence.
`ifndef CHAR_LCD_I2C_EXPANDER_SEQUENCER_MACROS_SVH
`define CHAR_LCD_I2C_EXPANDER_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the trigger.
`define CLCD_ASSERT_SAME(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cons)) \
        else $error("clcd assertion failed");

// The consequence must hold in the cycle after the trigger.
`define CLCD_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
        else $error("clcd assertion failed");

`else

`define CLCD_ASSERT_SAME(label, clk, rst_n, trig, cons)
`define CLCD_ASSERT_NEXT(label, clk, rst_n, trig, cons)

`endif

`endif

### hw/rtl/clcd_pkg.sv
package clcd_pkg;

    // Request codes on the input channel.
    typedef enum logic [1:0] {
        REQ_INIT   = 2'd0,
        REQ_CMD    = 2'd1,
        REQ_DATA   = 2'd2,
        REQ_CURSOR = 2'd3
    } t_req;

    // Where the nibble of an emitted byte comes from.
    typedef enum logic [1:0] {
        NIB_CONST = 2'd0,
        NIB_HIGH  = 2'd1,
        NIB_LOW   = 2'd2
    } t_nib_sel;

    // One microcode word: describes exactly one expander byte.
    typedef struct packed {
        t_nib_sel   sel;
        logic [3:0] nib;
        logic       en;
        logic       rs_req;
        logic       last;
    } t_uword;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        logic   load;
        logic   emit;
        t_uword uword;
    } t_seq_ctrl;

    // Expander bit positions.
    localparam int BIT_RS = 0;
    localparam int BIT_RW = 1;
    localparam int BIT_EN = 2;
    localparam int BIT_BL = 3;

    localparam int ROWS_DEFAULT = 2;

    // DDRAM start address of each display row.
    localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

    // Microprogram layout: the init routine, then the shared byte routine.
    localparam int UCODE_DEPTH = 42;
    localparam int UCODE_AW    = $clog2(UCODE_DEPTH);
    localparam logic [UCODE_AW-1:0] INIT_ENTRY = UCODE_AW'(0);
    localparam logic [UCODE_AW-1:0] BYTE_ENTRY = UCODE_AW'(36);
    localparam logic [UCODE_AW-1:0] INIT_LAST  = UCODE_AW'(35);
    localparam logic [UCODE_AW-1:0] BYTE_LAST  = UCODE_AW'(41);

    function automatic t_uword uw(t_nib_sel s, logic [3:0] n, logic e, logic r, logic l);
        t_uword w;
        w.sel    = s;
        w.nib    = n;
        w.en     = e;
        w.rs_req = r;
        w.last   = l;
        return w;
    endfunction

    // Each nibble is three bytes: enable low, enable high, enable low.
    // Init: nibbles 3, 3, 3, 2, then bytes 0x28, 0x0C, 0x01, 0x06.
    localparam t_uword UCODE [UCODE_DEPTH] = '{
        uw(NIB_CONST, 4'h3, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h3, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h3, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h3, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h3, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h3, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h3, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h3, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h3, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h2, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h2, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h2, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h2, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h2, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h2, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h8, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h8, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h8, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h0, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h0, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h0, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'hC, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'hC, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'hC, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h0, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h0, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h0, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h1, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h1, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h1, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h0, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h0, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h0, 1'b0, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h6, 1'b0, 1'b0, 1'b0), uw(NIB_CONST, 4'h6, 1'b1, 1'b0, 1'b0),
        uw(NIB_CONST, 4'h6, 1'b0, 1'b0, 1'b1),
        // Byte routine: high nibble then low nibble of the latched byte.
        uw(NIB_HIGH, 4'h0, 1'b0, 1'b1, 1'b0), uw(NIB_HIGH, 4'h0, 1'b1, 1'b1, 1'b0),
        uw(NIB_HIGH, 4'h0, 1'b0, 1'b1, 1'b0),
        uw(NIB_LOW, 4'h0, 1'b0, 1'b1, 1'b0), uw(NIB_LOW, 4'h0, 1'b1, 1'b1, 1'b0),
        uw(NIB_LOW, 4'h0, 1'b0, 1'b1, 1'b1)
    };

endpackage

### hw/rtl/clcd_seq.sv
`include "char_lcd_i2c_expander_sequencer_macros.svh"

module clcd_seq
    import clcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic       i_advance,
    output t_seq_ctrl  o_ctrl
);

    logic                r_busy;
    logic                n_busy;
    logic [UCODE_AW-1:0] r_pc;
    logic [UCODE_AW-1:0] n_pc;
    logic                accept;
    logic                emit;
    logic                at_last_word;
    t_uword              uword;

    assign o_in_ready = !r_busy;
    assign accept     = i_in_valid && !r_busy;
    assign emit       = r_busy && i_advance;

    // Microcode fetch; addresses past the program read as an empty word.
    assign uword = (r_pc < UCODE_AW'(UCODE_DEPTH)) ? UCODE[r_pc] : '0;

    assign o_ctrl.load  = accept;
    assign o_ctrl.emit  = emit;
    assign o_ctrl.uword = uword;

    // The step counter sits on the final word of one of the two routines.
    assign at_last_word = (r_pc == INIT_LAST) || (r_pc == BYTE_LAST);

    // Step counter: dispatch on request type, advance once per emitted byte,
    // and return to idle after the word marked last.
    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (accept) begin
            n_busy = 1'b1;
            n_pc   = (t_req'(i_req_type) == REQ_INIT) ? INIT_ENTRY : BYTE_ENTRY;
        end else if (emit) begin
            n_pc = r_pc + UCODE_AW'(1);
            if (uword.last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    // A transfer in starts a run on the next cycle.
    `CLCD_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, r_busy)
    // A run only ends at the final word of one of the two routines.
    `CLCD_ASSERT_SAME(a_last_at_end, i_clk, i_rst_n, emit && uword.last, at_last_word)
    // The step counter never leaves the program while running.
    `CLCD_ASSERT_SAME(a_pc_in_range, i_clk, i_rst_n, r_busy, r_pc < UCODE_AW'(UCODE_DEPTH))
    // After the final word the sequencer is idle again.
    `CLCD_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, emit && uword.last, !r_busy)

endmodule

### hw/rtl/clcd_datapath.sv
module clcd_datapath
    import clcd_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_seq_ctrl  i_ctrl,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_value,
    input  logic [5:0] i_col,
    input  logic [1:0] i_row,
    input  logic       i_backlight,
    output logic       o_advance,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_expander_byte,
    output logic       o_last
);

    logic [7:0] r_ctl_byte;
    logic       r_rs;
    logic [1:0] row_clamp;
    logic [7:0] cursor_cmd;
    logic [7:0] req_byte;
    logic [3:0] nib;
    logic [7:0] out_byte;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    // Set cursor: clamp the row, then add the row's DDRAM base to the column.
    assign row_clamp  = ({1'b0, i_row} >= 3'(ROWS)) ? 2'(ROWS - 1) : i_row;
    assign cursor_cmd = CMD_SET_DDRAM | ({2'b00, i_col} + ROW_BASE[row_clamp]);

    always_comb begin
        unique case (t_req'(i_req_type))
            REQ_CURSOR: req_byte = cursor_cmd;
            default:    req_byte = i_value;
        endcase
    end

    // Latch the controller byte and its register select on a transfer in.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_ctl_byte <= req_byte;
            r_rs       <= (t_req'(i_req_type) == REQ_DATA);
        end
    end

    // Nibble source chosen by the microcode word.
    always_comb begin
        unique case (i_ctrl.uword.sel)
            NIB_CONST: nib = i_ctrl.uword.nib;
            NIB_HIGH:  nib = r_ctl_byte[7:4];
            NIB_LOW:   nib = r_ctl_byte[3:0];
            default:   nib = '0;
        endcase
    end

    // Assemble the expander byte; read/write stays low.
    always_comb begin
        out_byte         = {nib, 4'b0000};
        out_byte[BIT_RS] = i_ctrl.uword.rs_req & r_rs;
        out_byte[BIT_RW] = 1'b0;
        out_byte[BIT_EN] = i_ctrl.uword.en;
        out_byte[BIT_BL] = i_backlight;
    end

    // Output register: loads whenever it is empty or being drained.
    assign o_advance = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_out_byte <= out_byte;
            r_out_last <= i_ctrl.uword.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_expander_byte = r_out_byte;
    assign o_last          = r_out_last;

endmodule

### hw/rtl/char_lcd_i2c_expander_sequencer.sv
// Character LCD sequencer for an HD44780 run in 4-bit mode behind an 8-bit
// I2C port expander. Each accepted request produces a run of expander bytes
// (bit 0 RS, bit 1 RW, bit 2 EN, bit 3 backlight, bits 7..4 nibble), with
// o_last marking the final byte of the run. Command, data and set cursor
// requests give 6 bytes, init gives 36. With the output always ready the
// block delivers one byte per cycle within a run. Each request is first
// taken in, then the microcode step counter fetches one control word per
// emitted byte; a stalled output holds the step counter. One request is
// worked on at a time: the next is taken as soon as the last byte of the
// current run sits in the output register. Backlight follows i_cfg_wdata
// written with i_cfg_we, and is on after reset.
module char_lcd_i2c_expander_sequencer
    import clcd_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_value,
    input  logic [5:0] i_col,
    input  logic [1:0] i_row,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_expander_byte,
    output logic       o_last
);

    logic      r_backlight_on;
    logic      advance;
    t_seq_ctrl ctrl;

    // Backlight configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight_on <= 1'b1;
        end else if (i_cfg_we) begin
            r_backlight_on <= i_cfg_wdata;
        end
    end

    clcd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_advance  (advance),
        .o_ctrl     (ctrl)
    );

    clcd_datapath #(
        .ROWS (ROWS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .i_col           (i_col),
        .i_row           (i_row),
        .i_backlight     (r_backlight_on),
        .o_advance       (advance),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_expander_byte (o_expander_byte),
        .o_last          (o_last)
    );

endmodule

### tb/clcd_byte_checker.sv
// Watches the request and expander-byte channels of the LCD sequencer,
// predicts the byte run of every accepted request and compares each
// transferred byte against the oldest prediction.
module clcd_byte_checker
    import clcd_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_value,
    input  logic [5:0] i_col,
    input  logic [1:0] i_row,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_expander_byte,
    input  logic       i_last,
    output int         o_pending,
    output int         o_fail_count,
    output int         o_bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] EN_MASK  = 8'h04;
    localparam logic [7:0] DDRAM_OP = 8'h80;
    localparam logic [7:0] LINE_START [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    typedef struct packed {
        logic [7:0] xbyte;
        logic       last;
    } t_lcd_byte;

    t_lcd_byte bytes_due [$];
    t_lcd_byte want;
    logic      backlight = 1'b1;
    int        fails = 0;
    int        checked = 0;

    // One nibble is strobed into the controller as three expander bytes:
    // enable low, enable high, enable low again.
    function automatic void push_nibble(input logic [3:0] nib, input logic rs,
                                        input logic ends_run);
        logic [7:0] base;
        base = {nib, backlight, 1'b0, 1'b0, rs};
        bytes_due.push_back('{xbyte: base, last: 1'b0});
        bytes_due.push_back('{xbyte: base | EN_MASK, last: 1'b0});
        bytes_due.push_back('{xbyte: base, last: ends_run});
    endfunction

    // A full controller byte goes out high nibble first.
    function automatic void push_controller_byte(input logic [7:0] b, input logic rs,
                                                 input logic ends_run);
        push_nibble(b[7:4], rs, 1'b0);
        push_nibble(b[3:0], rs, ends_run);
    endfunction

    // Set-DDRAM-address command; rows past the display are clamped to the
    // bottom row and the address sum wraps at eight bits.
    function automatic logic [7:0] cursor_command(input logic [5:0] col,
                                                  input logic [1:0] row);
        int line;
        line = (int'(row) >= ROWS) ? ROWS - 1 : int'(row);
        return DDRAM_OP | (8'(col) + LINE_START[line & 3]);
    endfunction

    function automatic void predict_request(input t_req kind, input logic [7:0] value,
                                            input logic [5:0] col, input logic [1:0] row);
        case (kind)
            REQ_INIT: begin
                push_nibble(4'h3, 1'b0, 1'b0);
                push_nibble(4'h3, 1'b0, 1'b0);
                push_nibble(4'h3, 1'b0, 1'b0);
                push_nibble(4'h2, 1'b0, 1'b0);
                // Function set, display on, clear, entry mode.
                push_controller_byte(8'h28, 1'b0, 1'b0);
                push_controller_byte(8'h0C, 1'b0, 1'b0);
                push_controller_byte(8'h01, 1'b0, 1'b0);
                push_controller_byte(8'h06, 1'b0, 1'b1);
            end
            REQ_CMD:  push_controller_byte(value, 1'b0, 1'b1);
            REQ_DATA: push_controller_byte(value, 1'b1, 1'b1);
            default:  push_controller_byte(cursor_command(col, row), 1'b0, 1'b1);
        endcase
    endfunction

    // Output transfers are checked before the request of the same edge is
    // predicted, so a byte can never match a request taken in that cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            backlight = 1'b1;
            bytes_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (bytes_due.size() == 0) begin
                    $display("%0t: unexpected expander byte %02h (last %0b), none expected",
                             $time, i_expander_byte, i_last);
                    fails++;
                end else begin
                    want = bytes_due.pop_front();
                    checked++;
                    if (i_expander_byte !== want.xbyte) begin
                        $display("%0t: expander byte mismatch, expected %02h, got %02h",
                                 $time, want.xbyte, i_expander_byte);
                        fails++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last flag mismatch, expected %0b, got %0b",
                                 $time, want.last, i_last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_request(t_req'(i_req_type), i_value, i_col, i_row);
            end
            if (i_cfg_we) begin
                backlight = i_cfg_wdata;
            end
        end
        o_pending       <= bytes_due.size();
        o_fail_count    <= fails;
        o_bytes_checked <= checked;
    end

endmodule

### tb/tb_char_lcd_i2c_expander_sequencer.sv
// Drives LCD requests and backlight settings into the sequencer, with
// random gaps on the request side and random stalls on the byte side.
module tb_char_lcd_i2c_expander_sequencer
    import clcd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = ROWS_DEFAULT;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_req       req_type = REQ_INIT;
    logic [7:0] value = 8'h00;
    logic [5:0] col = 6'd0;
    logic [1:0] row = 2'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] expander_byte;
    logic       last;

    int fail_count;
    int pending;
    int bytes_checked;
    int requests_by_kind [4] = '{0, 0, 0, 0};
    int backlight_writes = 0;
    bit fast_send = 1'b0;
    bit fast_take = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    char_lcd_i2c_expander_sequencer #(
        .ROWS(ROWS)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_value        (value),
        .i_col          (col),
        .i_row          (row),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_expander_byte(expander_byte),
        .o_last         (last)
    );

    clcd_byte_checker #(
        .ROWS(ROWS)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_value        (value),
        .i_col          (col),
        .i_row          (row),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_expander_byte(expander_byte),
        .i_last         (last),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_bytes_checked(bytes_checked)
    );

    // Present one request after a random gap and hold it until the transfer.
    // Valid stays high when the next request follows without a gap.
    task automatic send_request(input t_req kind, input logic [7:0] v,
                                input logic [5:0] c, input logic [1:0] r);
        int gap;
        if ($urandom_range(0, 9) == 0) fast_send = !fast_send;
        gap = fast_send ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        value    <= v;
        col      <= c;
        row      <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_by_kind[kind]++;
    endtask

    // The backlight register only changes once every expected byte is out
    // and the block has had time to go quiet.
    task automatic write_backlight(input logic bl);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= bl;
        @(posedge clk);
        cfg_we <= 1'b0;
        backlight_writes++;
    endtask

    // Byte side: a random stall before each transfer, with runs of none.
    initial begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 9) == 0) fast_take = !fast_take;
            stall = fast_take ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        t_req       kind;
        logic [7:0] v;
        logic [5:0] c;
        logic [1:0] r;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, backlight still at its reset setting.
        send_request(REQ_INIT,   8'h00, 6'd0,  2'd0);
        send_request(REQ_CMD,    8'h00, 6'd0,  2'd0);
        send_request(REQ_CMD,    8'hFF, 6'd0,  2'd0);
        send_request(REQ_CMD,    8'h01, 6'd0,  2'd0);   // clear display
        send_request(REQ_DATA,   8'h00, 6'd0,  2'd0);
        send_request(REQ_DATA,   8'hFF, 6'd0,  2'd0);
        send_request(REQ_DATA,   8'h5A, 6'd0,  2'd0);
        send_request(REQ_CURSOR, 8'h00, 6'd0,  2'd0);
        send_request(REQ_CURSOR, 8'h00, 6'd63, 2'd0);
        send_request(REQ_CURSOR, 8'h00, 6'd0,  2'd1);
        send_request(REQ_CURSOR, 8'h00, 6'd63, 2'd1);
        // Rows beyond the display are clamped.
        send_request(REQ_CURSOR, 8'h00, 6'd5,  2'd2);
        send_request(REQ_CURSOR, 8'h00, 6'd63, 2'd3);
        // Fields a request does not use must not leak into its bytes.
        send_request(REQ_INIT,   8'hFF, 6'd63, 2'd3);
        send_request(REQ_CMD,    8'hA5, 6'd63, 2'd3);
        send_request(REQ_CURSOR, 8'hFF, 6'd42, 2'd3);
        write_backlight(1'b0);
        send_request(REQ_INIT,   8'h00, 6'd0,  2'd0);
        send_request(REQ_DATA,   8'h3C, 6'd17, 2'd1);

        // Random part in four backlight phases; init is kept rare since it
        // is six times longer than the other requests.
        for (int phase = 0; phase < 4; phase++) begin
            write_backlight(phase == 3 ? 1'($urandom_range(0, 1)) : 1'(phase % 2 == 0));
            for (int k = 0; k < 23; k++) begin
                kind = ($urandom_range(0, 99) < 8) ? REQ_INIT : t_req'($urandom_range(1, 3));
                v = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                c = 6'($urandom_range(0, 63));
                if ($urandom_range(0, 5) == 0) c = $urandom_range(0, 1) ? 6'd63 : 6'd0;
                r = 2'($urandom_range(0, 3));
                send_request(kind, v, c, r);
            end
        end

        // Drain: wait for every expected byte, then a short quiet tail.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d requests: %0d init, %0d command, %0d data, %0d set cursor.",
                 requests_by_kind[0] + requests_by_kind[1] + requests_by_kind[2]
                 + requests_by_kind[3], requests_by_kind[REQ_INIT],
                 requests_by_kind[REQ_CMD], requests_by_kind[REQ_DATA],
                 requests_by_kind[REQ_CURSOR]);
        $display("Checked %0d expander bytes over %0d backlight writes with random flow control.",
                 bytes_checked, backlight_writes);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/clcd_pkg.sv
hw/rtl/clcd_seq.sv
hw/rtl/clcd_datapath.sv
hw/rtl/char_lcd_i2c_expander_sequencer.sv
tb/clcd_byte_checker.sv
tb/tb_char_lcd_i2c_expander_sequencer.sv
